// ===== src/bdqs_pkg.sv =====
`timescale 1ns / 1ps

package bdqs_pkg;

	// Store size; entry_count is seven bits wide, derived from this.
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// operation codes (6 and 7 behave as count)
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_COUNT      = 3'd4;
	localparam logic [2:0] OP_SEARCH     = 3'd5;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
		logic [1:0]       status;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;        // run a non-search request on the accepted payload
		logic scan_start;  // latch search value, rewind scan
		logic scan_run;    // issue scan reads
		logic scan_finish; // capture search result
		logic out_load;    // move pending result to output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_search;
		logic hit;
		logic scan_done;
	} dp_stat_t;

endpackage

// ===== src/bounded_deque_with_search_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Payload            Carries
// req      req_valid/req_stall  bdqs_pkg::req_t    one request: operation, value
// res      res_valid/res_stall  bdqs_pkg::res_t    one result per request
//
// Push, pop and count: accept, then load output.
// Search: accept, scan, load output; the single
// memory read port scans one entry per cycle from the front, stopping at the first match.
// arst_n clears front index, count and handshake state; store contents
// are not cleared and are never read before being written.
// A new request is taken while the last result still waits under res_stall.

module bounded_deque_with_search_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bdqs_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output bdqs_pkg::res_t res
);

	// command / status between sequencer and store
	bdqs_pkg::dp_cmd_t  cmd;
	bdqs_pkg::dp_stat_t st;

	// sequencer: idle -> (scan) -> load output -> idle
	bdqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// ring store, indices, scan pipeline and result registers
	bdqs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.res    (res)
	);

`ifndef SYNTHESIS
	// a request is never taken in the cycle straight after another
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted on consecutive cycles");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.entry_count <= bdqs_pkg::CNT_W'(bdqs_pkg::DEPTH)))
		else $error("entry count beyond depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.is_empty == (res.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.found) |-> (res.status == bdqs_pkg::ST_DONE))
		else $error("match reported with error status");
`endif

endmodule

// ===== src/bdqs_dp.sv =====
`timescale 1ns / 1ps

module bdqs_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bdqs_pkg::req_t    req,
	input  bdqs_pkg::dp_cmd_t cmd,
	output bdqs_pkg::dp_stat_t st,
	output bdqs_pkg::res_t    res
);

	localparam int IDX_W = bdqs_pkg::IDX_W;
	localparam int CNT_W = bdqs_pkg::CNT_W;

	// ring slot at base + off, off never above DEPTH
	function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(bdqs_pkg::DEPTH)) begin
			s = s - (CNT_W+1)'(bdqs_pkg::DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	logic [31:0]      mem [bdqs_pkg::DEPTH];
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_vld_s1;
	logic [31:0]      rdata_s1;
	logic [31:0]      val_q;
	bdqs_pkg::res_t   pend_q;
	bdqs_pkg::res_t   out_q;

	logic             full;
	logic             empty;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] nxt_front;
	logic [CNT_W-1:0] nxt_count;
	logic [1:0]       st_code;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic             issue;
	logic             hit;

	assign full      = (count_q == CNT_W'(bdqs_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(bdqs_pkg::DEPTH - 1) : front_q - 1'b1;

	always_comb begin
		nxt_front = front_q;
		nxt_count = count_q;
		st_code   = bdqs_pkg::ST_DONE;
		wr_en     = 1'b0;
		wr_addr   = front_dec;
		case (req.operation)
			bdqs_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					st_code = bdqs_pkg::ST_FULL;
				end else begin
					nxt_front = front_dec;
					nxt_count = count_q + 1'b1;
					wr_en     = cmd.exec;
				end
			end
			bdqs_pkg::OP_PUSH_BACK: begin
				wr_addr = slot_after(front_q, count_q);
				if (full) begin
					st_code = bdqs_pkg::ST_FULL;
				end else begin
					nxt_count = count_q + 1'b1;
					wr_en     = cmd.exec;
				end
			end
			bdqs_pkg::OP_POP_FRONT: begin
				if (empty) begin
					st_code = bdqs_pkg::ST_EMPTY;
				end else begin
					nxt_front = slot_after(front_q, CNT_W'(1));
					nxt_count = count_q - 1'b1;
				end
			end
			bdqs_pkg::OP_POP_BACK: begin
				if (empty) begin
					st_code = bdqs_pkg::ST_EMPTY;
				end else begin
					nxt_count = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// scan: one read per cycle, compare in the cycle after
	assign issue   = cmd.scan_run && (issue_q < count_q);
	assign rd_addr = slot_after(front_q, issue_q);
	assign hit     = rd_vld_s1 && (rdata_s1 == val_q);

	assign st.is_search = (req.operation == bdqs_pkg::OP_SEARCH);
	assign st.hit       = hit;
	assign st.scan_done = (issue_q == count_q) && !rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.exec) begin
				front_q <= nxt_front;
				count_q <= nxt_count;
			end
			if (cmd.scan_start) begin
				issue_q   <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					issue_q <= issue_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.value;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			val_q <= req.value;
		end
		if (cmd.exec) begin
			pend_q.found       <= 1'b0;
			pend_q.entry_count <= nxt_count;
			pend_q.is_empty    <= (nxt_count == '0);
			pend_q.status      <= st_code;
		end else if (cmd.scan_finish) begin
			pend_q.found       <= hit;
			pend_q.entry_count <= count_q;
			pend_q.is_empty    <= empty;
			pend_q.status      <= bdqs_pkg::ST_DONE;
		end
		if (cmd.out_load) begin
			out_q <= pend_q;
		end
	end

	assign res = out_q;

endmodule

// ===== src/bdqs_ctrl.sv =====
`timescale 1ns / 1ps

module bdqs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               res_valid,
	input  logic               res_stall,
	input  bdqs_pkg::dp_stat_t st,
	output bdqs_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_LOAD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   res_valid_q;
	logic   out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (st.is_search) begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end else begin
						cmd.exec  = 1'b1;
						state_nxt = S_LOAD;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.hit || st.scan_done) begin
					cmd.scan_finish = 1'b1;
					state_nxt       = S_LOAD;
				end
			end
			S_LOAD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ===== test/bounded_deque_with_search_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bounded deque with search.
// A shadow copy of the ring (front slot, fill level, stored words) predicts
// one result per accepted request; results are checked in order.
module bounded_deque_with_search_unit_tb;
	import bdqs_pkg::*;

	// Codes 6 and 7 are unused and must behave as count.
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS   = 100;    // tail of the run with no idling
	localparam int CYCLE_LIMIT  = 400000; // watchdog limit on run length

	// Traffic mix for one stretch of random requests.
	typedef enum {FILL_UP, MIXED, DRAIN} traffic_t;

	// Shadow of the deque: predicts each result and holds the ones due.
	class deque_shadow;
		logic [31:0]      slots [DEPTH];
		logic [IDX_W-1:0] front;
		logic [CNT_W-1:0] fill;
		res_t             pending_results [$];
		int               mismatches;

		function new();
			front = '0;
			fill = '0;
			mismatches = 0;
		endfunction

		function void note_request(req_t r);
			res_t want;
			want = '0;
			want.status = ST_DONE;
			case (r.operation)
				OP_PUSH_FRONT: begin
					if (int'(fill) >= DEPTH) begin
						want.status = ST_FULL;
					end else begin
						front = front - 1'b1;
						slots[front] = r.value;
						fill = fill + 1'b1;
					end
				end
				OP_PUSH_BACK: begin
					if (int'(fill) >= DEPTH) begin
						want.status = ST_FULL;
					end else begin
						slots[IDX_W'(front + fill)] = r.value;
						fill = fill + 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (fill == 0) begin
						want.status = ST_EMPTY;
					end else begin
						front = front + 1'b1;
						fill = fill - 1'b1;
					end
				end
				OP_POP_BACK: begin
					if (fill == 0) begin
						want.status = ST_EMPTY;
					end else begin
						fill = fill - 1'b1;
					end
				end
				OP_SEARCH: begin
					for (int i = 0; i < fill; i++) begin
						if (slots[IDX_W'(front + i)] == r.value) begin
							want.found = 1'b1;
							break;
						end
					end
				end
				default: begin
				end
			endcase
			want.entry_count = fill;
			want.is_empty = (fill == 0);
			pending_results.push_back(want);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result with none expected: %p", got);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, got.found);
					mismatches++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, got.entry_count);
					mismatches++;
				end
				if (got.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, actual %0d",
						want.is_empty, got.is_empty);
					mismatches++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					mismatches++;
				end
			end
		endfunction

		// A word currently held, so searches can hit.
		function logic [31:0] pick_stored();
			if (fill == 0)
				return $urandom;
			return slots[IDX_W'(front + $urandom_range(0, fill - 1))];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	deque_shadow shadow;

	// Idling controls, retuned for each stretch of random requests.
	int   tx_gap_pct = 0;
	int   rx_stall_pct = 0;
	bit   calm = 1'b0;
	int   stall_left = 0;
	int   cycle_count = 0;

	bounded_deque_with_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Presents one request, holds it until taken, then logs it in the shadow.
	// A random gap may come first; valid is dropped for the whole gap.
	task automatic send_request(input logic [2:0] operation, input logic [31:0] value);
		req_t r;
		r.operation = operation;
		r.value = value;
		if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		shadow.note_request(r);
	endtask

	// Operation mix: filling stretches reach full, draining ones reach empty,
	// so the push-when-full and pop-when-empty cases get plenty of hits.
	function automatic logic [2:0] pick_operation(traffic_t m);
		int r;
		r = $urandom_range(0, 99);
		case (m)
			FILL_UP: begin
				if (r < 40) return OP_PUSH_FRONT;
				if (r < 80) return OP_PUSH_BACK;
				if (r < 84) return OP_POP_FRONT;
				if (r < 88) return OP_POP_BACK;
				if (r < 96) return OP_SEARCH;
				if (r < 98) return OP_COUNT;
			end
			DRAIN: begin
				if (r < 38) return OP_POP_FRONT;
				if (r < 76) return OP_POP_BACK;
				if (r < 82) return OP_PUSH_FRONT;
				if (r < 88) return OP_PUSH_BACK;
				if (r < 96) return OP_SEARCH;
				if (r < 98) return OP_COUNT;
			end
			default: begin
				if (r < 18) return OP_PUSH_FRONT;
				if (r < 36) return OP_PUSH_BACK;
				if (r < 50) return OP_POP_FRONT;
				if (r < 64) return OP_POP_BACK;
				if (r < 90) return OP_SEARCH;
				if (r < 96) return OP_COUNT;
			end
		endcase
		return (r % 2 == 0) ? OP_SPARE_A : OP_SPARE_B;
	endfunction

	// Values: extremes, a narrow band near zero (so duplicates occur) and
	// full-range words.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1, 2, 3: return $urandom_range(0, 15);
			4: return 32'hffff_ffff - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Result side: random stall bursts, none in the calm tail.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
			stall_left = $urandom_range(0, 8);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Every accepted result is compared against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			shadow.check_result(res);
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          sent;
		int          stretch;
		traffic_t    mode;
		logic [2:0]  op;
		logic [31:0] v;

		shadow = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests, no idling: empty-store corner cases first,
		// then front-index wrap on push front, the value extremes, hits and
		// misses, spare codes and a drain back to empty.
		send_request(OP_COUNT, 32'h1234_5678);
		send_request(OP_POP_FRONT, 32'h0);
		send_request(OP_POP_BACK, 32'hffff_ffff);
		send_request(OP_SEARCH, 32'h0);
		send_request(OP_SPARE_A, 32'h0);
		send_request(OP_PUSH_FRONT, 32'h7fff_ffff);
		send_request(OP_PUSH_BACK, 32'h8000_0000);
		send_request(OP_PUSH_FRONT, 32'h0);
		send_request(OP_PUSH_BACK, 32'hffff_ffff);
		send_request(OP_SEARCH, 32'h8000_0000);
		send_request(OP_SEARCH, 32'h7fff_ffff);
		send_request(OP_SEARCH, 32'h1);
		send_request(OP_SEARCH, 32'hffff_ffff);
		send_request(OP_SPARE_B, 32'hffff_ffff);
		send_request(OP_POP_FRONT, 32'h5555_5555);
		send_request(OP_POP_BACK, 32'haaaa_aaaa);
		send_request(OP_SEARCH, 32'h0);
		send_request(OP_POP_FRONT, 32'h0);
		send_request(OP_POP_BACK, 32'h0);
		send_request(OP_POP_BACK, 32'h0);
		send_request(OP_PUSH_BACK, 32'h5555_5555);
		send_request(OP_PUSH_FRONT, 32'haaaa_aaaa);
		send_request(OP_SEARCH, 32'haaaa_aaaa);
		send_request(OP_POP_FRONT, 32'h0);

		// Random stretches cycling fill / mixed / drain, each with its own
		// idling levels (sometimes none at all).
		sent = 0;
		mode = FILL_UP;
		while (sent < RANDOM_ITEMS) begin
			stretch = $urandom_range(100, 140);
			tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
			rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
			repeat (stretch) begin
				if (sent >= RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
				op = pick_operation(mode);
				if (op == OP_SEARCH && $urandom_range(0, 1) == 1)
					v = shadow.pick_stored();
				else
					v = pick_value();
				send_request(op, v);
				sent++;
			end
			mode = (mode == FILL_UP) ? MIXED : (mode == MIXED) ? DRAIN : FILL_UP;
		end
		req_valid <= 1'b0;

		// Drain outstanding results, then watch for strays.
		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		if (shadow.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
